// ----- hw/rtl/tnrd_pkg.sv -----
`default_nettype none

package tnrd_pkg;

  // Widths of the counters and the limit register
  localparam int CNT_W      = 13;
  localparam int MAX_RECORD = 4096;
  localparam int MIN_LIMIT  = 2;
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(MAX_RECORD);

  // Telnet command bytes
  localparam logic [7:0] CH_EOR  = 8'd239;
  localparam logic [7:0] CH_SE   = 8'd240;
  localparam logic [7:0] CH_BRK  = 8'd243;
  localparam logic [7:0] CH_IP   = 8'd244;
  localparam logic [7:0] CH_SB   = 8'd250;
  localparam logic [7:0] CH_WILL = 8'd251;
  localparam logic [7:0] CH_DONT = 8'd254;
  localparam logic [7:0] CH_IAC  = 8'd255;

  // Input operation codes
  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_CLOSED = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Record end causes
  localparam logic [1:0] END_EOR = 2'd0;
  localparam logic [1:0] END_BRK = 2'd1;
  localparam logic [1:0] END_IP  = 2'd2;

  // Error causes
  localparam logic ERR_OVERFLOW = 1'b0;
  localparam logic ERR_CLOSED   = 1'b1;

  typedef enum logic [4:0] {
    PH_DATA   = 5'b00001,
    PH_CMD    = 5'b00010,
    PH_OPT    = 5'b00100,
    PH_SUB    = 5'b01000,
    PH_SUBCMD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data_byte;
    logic [1:0]       end_cause;
    logic             error_cause;
    logic [CNT_W-1:0] record_length;
  } res_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/telnet_record_deframer_core.sv -----
`default_nettype none

// Telnet record deframer. Each rx beat carries one received telnet byte or
// a connection-closed event; each res beat carries one result: a stripped
// data byte, a record end (EOR, BRK or IP after IAC, with the count of data
// bytes in the record), or an error (raw byte count reached record_limit,
// or connection closed). Commands, option bytes and subnegotiations give no
// result. The block takes one rx beat per cycle, sustained, as long as the
// result side keeps taking beats: a beat lands in an input register, the
// parse logic runs in the cycle it moves on, and any result lands in the
// output register, so a result is offered on res at the earliest once its
// rx beat has passed both registers. The parse state loop (phase and two
// counters) sets that rate. The user must write record_limit through
// cfg_we and cfg_wdata only while the block is idle; the block does not
// enforce this. Values below 2 act as 2 and values above 4096 act as 4096.
module telnet_record_deframer_core (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_we,
  input  wire [tnrd_pkg::CNT_W-1:0]  cfg_wdata,
  input  wire                        rx_valid,
  output logic                       rx_ready,
  input  tnrd_pkg::rx_item_t         rx_item,
  output logic                       res_valid,
  input  wire                        res_ready,
  output tnrd_pkg::res_item_t        res_item
);
  import tnrd_pkg::*;

  // Input register
  logic      in_q_valid;
  rx_item_t  in_q;

  // Parse outputs
  logic      has_result;
  res_item_t result;

  // Move the held beat through the parser when the output slot is free
  logic      advance;

  assign advance  = in_q_valid && (!res_valid || res_ready);
  assign rx_ready = !in_q_valid || advance;

  // Capture a new rx beat; drop the held one once it has advanced
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      in_q <= rx_item;
    end
  end

  tnrd_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .step       (advance),
    .item       (in_q),
    .has_result (has_result),
    .result     (result)
  );

  // Output register: load a result, otherwise release on a taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && has_result) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      res_item <= result;
    end
  end

  // A held input beat that cannot advance stays put
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid && $stable(in_q))
    else $error("input register lost or changed a stalled beat");

  // Every parsed result reaches the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance && has_result |=> res_valid)
    else $error("parse result not loaded into output register");

  // Result kind is always one of the three legal codes
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_item.kind == KIND_DATA || res_item.kind == KIND_END ||
                   res_item.kind == KIND_ERROR))
    else $error("illegal result kind");

  // A record never reports more data bytes than the largest record
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.kind == KIND_END |->
      res_item.record_length <= CNT_W'(MAX_RECORD))
    else $error("record length above maximum");

endmodule

`default_nettype wire

// ----- hw/rtl/tnrd_parse.sv -----
`default_nettype none

module tnrd_parse (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_we,
  input  wire [tnrd_pkg::CNT_W-1:0]  cfg_wdata,
  input  wire                        step,
  input  tnrd_pkg::rx_item_t         item,
  output logic                       has_result,
  output tnrd_pkg::res_item_t        result
);
  import tnrd_pkg::*;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] raw_count, raw_count_next;
  logic [CNT_W-1:0] data_count, data_count_next;
  logic [CNT_W-1:0] record_limit;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] raw_inc;
  logic             is_end;
  logic [1:0]       end_code;

  // Clamp the limit into its legal range
  always_comb begin
    if (record_limit < CNT_W'(MIN_LIMIT)) begin
      lim = CNT_W'(MIN_LIMIT);
    end else if (record_limit > CNT_W'(MAX_RECORD)) begin
      lim = CNT_W'(MAX_RECORD);
    end else begin
      lim = record_limit;
    end
  end

  always_comb begin
    is_end   = 1'b1;
    end_code = END_EOR;
    case (item.rx_byte)
      CH_EOR:  end_code = END_EOR;
      CH_BRK:  end_code = END_BRK;
      CH_IP:   end_code = END_IP;
      default: is_end   = 1'b0;
    endcase
  end

  assign raw_inc = raw_count + CNT_W'(1);

  always_comb begin
    phase_next      = phase;
    raw_count_next  = raw_count;
    data_count_next = data_count;
    has_result      = 1'b0;
    result          = '0;
    if (item.op == OP_CLOSED) begin
      phase_next         = PH_DATA;
      raw_count_next     = '0;
      data_count_next    = '0;
      has_result         = 1'b1;
      result.kind        = KIND_ERROR;
      result.error_cause = ERR_CLOSED;
    end else if ((phase == PH_CMD || phase == PH_SUBCMD) && is_end) begin
      phase_next           = PH_DATA;
      raw_count_next       = '0;
      data_count_next      = '0;
      has_result           = 1'b1;
      result.kind          = KIND_END;
      result.end_cause     = end_code;
      result.record_length = data_count;
    end else if (raw_inc >= lim) begin
      phase_next         = PH_DATA;
      raw_count_next     = '0;
      data_count_next    = '0;
      has_result         = 1'b1;
      result.kind        = KIND_ERROR;
      result.error_cause = ERR_OVERFLOW;
    end else begin
      raw_count_next = raw_inc;
      case (phase)
        PH_DATA: begin
          if (item.rx_byte == CH_IAC) begin
            phase_next = PH_CMD;
          end else begin
            data_count_next  = data_count + CNT_W'(1);
            has_result       = 1'b1;
            result.kind      = KIND_DATA;
            result.data_byte = item.rx_byte;
          end
        end
        PH_CMD: begin
          if (item.rx_byte == CH_IAC) begin
            phase_next       = PH_DATA;
            data_count_next  = data_count + CNT_W'(1);
            has_result       = 1'b1;
            result.kind      = KIND_DATA;
            result.data_byte = CH_IAC;
          end else if (item.rx_byte inside {[CH_WILL:CH_DONT]}) begin
            phase_next = PH_OPT;
          end else if (item.rx_byte == CH_SB) begin
            phase_next = PH_SUB;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_OPT: begin
          phase_next = PH_DATA;
        end
        PH_SUB: begin
          if (item.rx_byte == CH_IAC) begin
            phase_next = PH_SUBCMD;
          end
        end
        PH_SUBCMD: begin
          phase_next = (item.rx_byte == CH_SE) ? PH_DATA : PH_SUB;
        end
        default: begin
          phase_next = PH_DATA;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_DATA;
      raw_count  <= '0;
      data_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      raw_count  <= raw_count_next;
      data_count <= data_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      record_limit <= cfg_wdata;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

// Testbench for telnet_record_deframer_core.
//
// A sender task pushes one rx beat at a time and updates a predictor of the
// deframer when the beat is accepted. Any result that the predictor expects
// goes into a queue. A checker process takes each res beat and compares it,
// field by field, with the oldest entry of that queue. Both sides insert
// random gaps. There are calm stretches without gaps, and there is one long
// receiver hold-off that fills the block and stalls its input. A watchdog
// ends the run when no beat moves for too long.
module tb_top;
  import tnrd_pkg::*;

  localparam int LONG_HOLD      = 300;   // receiver hold-off for the pressure test
  localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before declaring a hang
  localparam int DRAIN_CYCLES   = 6;     // block latency plus margin
  localparam int PHASE_BEATS    = 140;   // random beats per limit setting

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             rx_valid = 1'b0;
  logic             rx_ready;
  rx_item_t         rx_item = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  res_item_t        res_item;

  // Predictor state: parse phase, both record counters and the limit register
  phase_t           parse_ph;
  logic [CNT_W-1:0] raw_seen;
  logic [CNT_W-1:0] data_passed;
  logic [CNT_W-1:0] limit_reg;

  res_item_t        due_results[$];  // results the deframer still owes
  int               mismatches = 0;
  int               bytes_in = 0;
  int               idle_cycles = 0;
  bit               rx_calm = 1'b0;  // sender: no gaps while set
  bit               res_calm = 1'b0; // receiver: no stalls while set
  bit               long_hold = 1'b0;
  int               ready_hold = 0;

  telnet_record_deframer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_item   (rx_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void start_record();
    parse_ph    = PH_DATA;
    raw_seen    = '0;
    data_passed = '0;
  endfunction

  // Advance the deframer model by one accepted beat and queue any result.
  // Order of precedence: close, then a record end after IAC (which wins over
  // the limit), then overflow, then the ordinary parse step.
  function automatic void deframe_beat(input rx_item_t it);
    logic [CNT_W-1:0] lim;
    res_item_t        r;
    logic             is_end;
    logic [1:0]       cause;
    r      = '0;
    is_end = 1'b0;
    cause  = END_EOR;
    if (it.op == OP_CLOSED) begin
      start_record();
      r.kind        = KIND_ERROR;
      r.error_cause = ERR_CLOSED;
      due_results.push_back(r);
    end else begin
      // Clamp the limit into the range the block honors
      lim = limit_reg;
      if (lim < MIN_LIMIT) lim = CNT_W'(MIN_LIMIT);
      else if (lim > MAX_RECORD) lim = CNT_W'(MAX_RECORD);
      raw_seen = raw_seen + 1'b1;
      case (it.rx_byte)
        CH_EOR: begin
          is_end = 1'b1;
          cause  = END_EOR;
        end
        CH_BRK: begin
          is_end = 1'b1;
          cause  = END_BRK;
        end
        CH_IP: begin
          is_end = 1'b1;
          cause  = END_IP;
        end
        default: ;
      endcase
      if (is_end && (parse_ph == PH_CMD || parse_ph == PH_SUBCMD)) begin
        r.kind          = KIND_END;
        r.end_cause     = cause;
        r.record_length = data_passed;
        start_record();
        due_results.push_back(r);
      end else if (raw_seen >= lim) begin
        r.kind        = KIND_ERROR;
        r.error_cause = ERR_OVERFLOW;
        start_record();
        due_results.push_back(r);
      end else begin
        case (parse_ph)
          PH_DATA: begin
            if (it.rx_byte == CH_IAC) begin
              parse_ph = PH_CMD;
            end else begin
              data_passed = data_passed + 1'b1;
              r.kind      = KIND_DATA;
              r.data_byte = it.rx_byte;
              due_results.push_back(r);
            end
          end
          PH_CMD: begin
            if (it.rx_byte == CH_IAC) begin
              // Escaped IAC: one 255 data byte
              parse_ph    = PH_DATA;
              data_passed = data_passed + 1'b1;
              r.kind      = KIND_DATA;
              r.data_byte = CH_IAC;
              due_results.push_back(r);
            end else if (it.rx_byte >= CH_WILL && it.rx_byte <= CH_DONT) begin
              parse_ph = PH_OPT;
            end else if (it.rx_byte == CH_SB) begin
              parse_ph = PH_SUB;
            end else begin
              parse_ph = PH_DATA;
            end
          end
          PH_OPT: parse_ph = PH_DATA;
          PH_SUB: begin
            if (it.rx_byte == CH_IAC) parse_ph = PH_SUBCMD;
          end
          PH_SUBCMD: parse_ph = (it.rx_byte == CH_SE) ? PH_DATA : PH_SUB;
          default: parse_ph = PH_DATA;
        endcase
      end
    end
  endfunction

  // Offer one beat, hold it until accepted, then predict and maybe idle.
  task automatic send_beat(input logic op, input logic [7:0] b);
    rx_item_t it;
    int       gap;
    it.op      = op;
    it.rx_byte = b;
    rx_item  <= it;
    rx_valid <= 1'b1;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    deframe_beat(it);
    bytes_in++;
    gap = pick_gap(rx_calm);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every owed result, then wait out a margin so that a
  // beat that gives no result leaves the pipeline before the block is idle.
  task automatic drain();
    rx_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg  = v;
  endtask

  // Data extremes, escaped IAC, option bytes (also 255), an unknown
  // command, a subnegotiation with an inner non-SE command, and every
  // record end cause, one of them inside a subnegotiation.
  task automatic test_parse_directed();
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'hFE);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, CH_WILL);
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, 8'd241);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, CH_SB);
    send_beat(OP_BYTE, 8'h01);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, 8'h05);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, CH_SE);
    send_beat(OP_BYTE, 8'h41);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, CH_EOR);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, CH_SB);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, CH_BRK);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, CH_IP);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_CLOSED, 8'h00);
  endtask

  // Limits below the floor, a record end landing on the limit, and a close
  // in the data phase and inside a subnegotiation.
  task automatic test_limit_edges();
    write_limit('0);
    send_beat(OP_BYTE, 8'h11);
    send_beat(OP_BYTE, 8'h22);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, CH_EOR);
    send_beat(OP_CLOSED, 8'hFF);
    write_limit(13'd3);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, CH_SB);
    send_beat(OP_CLOSED, 8'h00);
    send_beat(OP_BYTE, 8'h33);
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, CH_EOR);
    write_limit(13'd1);
    send_beat(OP_BYTE, 8'h44);
    send_beat(OP_BYTE, CH_IAC);
  endtask

  // A limit above the ceiling acts as 4096, not as some small value: a
  // record well past the floor still ends cleanly.
  task automatic test_limit_ceiling();
    write_limit(13'h1FFF);
    repeat (120) send_beat(OP_BYTE, 8'($urandom_range(0, 254)));
    send_beat(OP_BYTE, CH_IAC);
    send_beat(OP_BYTE, CH_EOR);
  endtask

  // Hold off the receiver for a long stretch while data beats keep coming.
  task automatic test_backpressure();
    write_limit(CNT_W'(MAX_RECORD));
    long_hold = 1'b1;
    rx_calm   = 1'b1;
    repeat (60) send_beat(OP_BYTE, 8'($urandom_range(0, 254)));
    rx_calm   = 1'b0;
  endtask

  // Mostly well-formed telnet traffic with random content, plus noise,
  // under a series of limit settings.
  task automatic test_random_traffic();
    logic [CNT_W-1:0] plan [8];
    int               sel;
    int               n;
    int               stop_at;
    plan = '{13'd4096, 13'd2, 13'd5, 13'd0, 13'd40, 13'h1FFF, 13'd1, 13'd17};
    for (int p = 0; p < 8; p++) begin
      write_limit((p == 7) ? CNT_W'($urandom_range(2, 300)) : plan[p]);
      stop_at = bytes_in + PHASE_BEATS;
      while (bytes_in < stop_at) begin
        if ($urandom_range(0, 9) == 0) rx_calm = !rx_calm;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
          n = $urandom_range(1, 8);
          repeat (n) send_beat(OP_BYTE, 8'($urandom_range(0, 254)));
        end else if (sel < 43) begin
          send_beat(OP_BYTE, CH_IAC);
          send_beat(OP_BYTE, CH_IAC);
        end else if (sel < 55) begin
          send_beat(OP_BYTE, CH_IAC);
          send_beat(OP_BYTE, 8'($urandom_range(CH_WILL, CH_DONT)));
          send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
        end else if (sel < 65) begin
          // Subnegotiation: random body, sometimes an inner command,
          // usually closed by IAC SE, sometimes cut by a record end
          send_beat(OP_BYTE, CH_IAC);
          send_beat(OP_BYTE, CH_SB);
          n = $urandom_range(0, 5);
          repeat (n) begin
            if ($urandom_range(0, 5) == 0) begin
              send_beat(OP_BYTE, CH_IAC);
              send_beat(OP_BYTE, 8'($urandom_range(0, 238)));
            end else begin
              send_beat(OP_BYTE, 8'($urandom_range(0, 254)));
            end
          end
          send_beat(OP_BYTE, CH_IAC);
          case ($urandom_range(0, 5))
            0:       send_beat(OP_BYTE, CH_EOR);
            1:       send_beat(OP_BYTE, CH_IP);
            default: send_beat(OP_BYTE, CH_SE);
          endcase
        end else if (sel < 72) begin
          send_beat(OP_BYTE, CH_IAC);
          send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
        end else if (sel < 88) begin
          send_beat(OP_BYTE, CH_IAC);
          case ($urandom_range(0, 2))
            0:       send_beat(OP_BYTE, CH_EOR);
            1:       send_beat(OP_BYTE, CH_BRK);
            default: send_beat(OP_BYTE, CH_IP);
          endcase
        end else if (sel < 92) begin
          send_beat(OP_CLOSED, 8'($urandom_range(0, 255)));
        end else begin
          n = $urandom_range(1, 4);
          repeat (n) send_beat(($urandom_range(0, 7) == 0) ? OP_CLOSED : OP_BYTE,
                               8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Receiver: random stalls, calm stretches, and the long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) res_calm = !res_calm;
      if (long_hold) begin
        ready_hold = LONG_HOLD;
        long_hold  = 1'b0;
      end
      if (ready_hold > 0) begin
        ready_hold--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        ready_hold = pick_gap(res_calm);
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare every res beat with the oldest owed result.
  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind=%0d byte=%0d len=%0d",
                 $time, res_item.kind, res_item.data_byte, res_item.record_length);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(res_item.kind));
        check_field("data_byte", 16'(want.data_byte), 16'(res_item.data_byte));
        check_field("end_cause", 16'(want.end_cause), 16'(res_item.end_cause));
        check_field("error_cause", 16'(want.error_cause), 16'(res_item.error_cause));
        check_field("record_length", 16'(want.record_length),
                    16'(res_item.record_length));
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((rx_valid && rx_ready) || (res_valid && res_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    start_record();
    limit_reg = LIMIT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_parse_directed();
    test_limit_edges();
    test_backpressure();
    test_random_traffic();
    test_limit_ceiling();
    drain();
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/tnrd_pkg.sv
hw/rtl/tnrd_parse.sv
hw/rtl/telnet_record_deframer_core.sv
tb/tb_top.sv
